// File: hw/rtl/dasb_pkg.sv
// ----------------------------------------------------------------------------
// dasb_pkg: shared types and constants of the delay-and-sum beamformer
// Register indexes, reset values, item codes and sequencer state codes.
// ----------------------------------------------------------------------------
package dasb_pkg;

	// configuration port
	localparam int CfgIndexBits = 3;
	localparam int CfgDataBits  = 28;

	typedef enum logic [CfgIndexBits-1:0] {
		REG_RECEIVER_COUNT = 3'd0,
		REG_SAMPLE_COUNT   = 3'd1,
		REG_SOUND_SPEED    = 3'd2,
		REG_ARRAY_WIDTH    = 3'd3,
		REG_SAMPLE_RATE    = 3'd4,
		REG_START_DEPTH    = 3'd5,
		REG_AREA_HEIGHT    = 3'd6,
		REG_ROW_COUNT      = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [7:0]  RstReceiverCount = 8'd128;
	localparam logic [12:0] RstSampleCount   = 13'd4096;
	localparam logic [23:0] RstSoundSpeed    = 24'd1540000;
	localparam logic [19:0] RstArrayWidth    = 20'd38400;
	localparam logic [27:0] RstSampleRate    = 28'd50000000;
	localparam logic [19:0] RstStartDepth    = 20'd0;
	localparam logic [19:0] RstAreaHeight    = 20'd50000;
	localparam logic [10:0] RstRowCount      = 11'd1024;

	// item codes
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_COMPUTE = 1'b1;

	// result and geometry widths
	localparam int PixelBits   = 24;
	localparam int RowBits     = 10;
	localparam int GeoQuotBits = 28;   // Q8 lateral and depth positions
	localparam int SqrtSteps   = 30;   // radicand below 2^59
	localparam int SqrtTopBit  = 58;
	localparam int DatBits     = 64;   // shared compare-subtract width
	localparam int MulABits    = 35;
	localparam int MulBBits    = 32;
	localparam int SpeedScale  = 1000; // mm/s to um/s

	// sequencer states
	typedef enum logic [20:0] {
		S_IDLE = 21'h000001,
		S_TD   = 21'h000002,
		S_LIM  = 21'h000004,
		S_ROW  = 21'h000008,
		S_YLD  = 21'h000010,
		S_YDIV = 21'h000020,
		S_YSQ  = 21'h000040,
		S_YSQW = 21'h000080,
		S_XM   = 21'h000100,
		S_XLD  = 21'h000200,
		S_XDIV = 21'h000400,
		S_DX   = 21'h000800,
		S_RAD  = 21'h001000,
		S_SQRT = 21'h002000,
		S_PM   = 21'h004000,
		S_PCHK = 21'h008000,
		S_PDIV = 21'h010000,
		S_RD0  = 21'h020000,
		S_RD1  = 21'h040000,
		S_INT  = 21'h080000,
		S_DONE = 21'h100000
	} state_t;

endpackage

// File: hw/rtl/delay_and_sum_beamformer_unit.sv
// ----------------------------------------------------------------------------
// delay_and_sum_beamformer_unit: delay-and-sum beamformer for one transmit
// Stores echo samples per receiver and forms one centre-line pixel per
// compute item from linearly interpolated, delay-aligned samples.
// ----------------------------------------------------------------------------
// A load item is taken and the block stays ready. A compute item works, for
// each receiver in use, through 28 divide steps for its lateral position,
// 30 square-root steps for the path length, log2(MAX_SAMPLES) + 8 divide
// steps for the sample position and its multiplies and echo memory reads. A
// receiver whose echo lands beyond the recording skips the last divide and
// the reads. All divide, square-root and range-check steps share one 64-bit
// compare-subtract unit, and all geometry products share one multiplier; the
// block stalls its input until the pixel is in the output register.
module delay_and_sum_beamformer_unit
	import dasb_pkg::*;
#(
	parameter int MAX_RECEIVERS = 128,
	parameter int MAX_SAMPLES   = 4096,
	parameter int MAX_ROWS      = 1024,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [6:0]                    receiver_index,
	input  logic [11:0]                   sample_index,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic [RowBits-1:0]            depth_row,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [PixelBits-1:0]   pixel_value,
	output logic [RowBits-1:0]            row_out,
	input  logic                          wr_en,
	input  logic [CfgIndexBits-1:0]       wr_index,
	input  logic [CfgDataBits-1:0]        wr_data
);

	localparam int NW   = $clog2(MAX_RECEIVERS);
	localparam int NCW  = $clog2(MAX_RECEIVERS + 1);
	localparam int SW   = $clog2(MAX_SAMPLES);
	localparam int SCW  = $clog2(MAX_SAMPLES + 1);
	localparam int QP   = SW + 8;
	localparam int AW   = NW + SW;
	localparam int ACW  = SAMPLE_BITS + NW + 1;
	localparam int XW   = (ACW > PixelBits) ? ACW : PixelBits + 1;
	localparam int RRW  = $clog2(MAX_ROWS + 1) > 11 ? $clog2(MAX_ROWS + 1) : 11;

	// configuration registers
	logic [7:0]  receiver_count_q;
	logic [12:0] sample_count_q;
	logic [23:0] sound_speed_q;
	logic [19:0] array_width_q;
	logic [27:0] sample_rate_q;
	logic [19:0] start_depth_q;
	logic [19:0] area_height_q;
	logic [10:0] row_count_q;

	// sequencer and datapath
	state_t                      state_q;
	logic [RowBits-1:0]          row_in_q;
	logic [NCW-1:0]              n_q;
	logic [33:0]                 time_div_q;
	logic [DatBits-1:0]          limit_q;
	logic [28:0]                 y_q;
	logic [DatBits-1:0]          ysq_q;
	logic [GeoQuotBits-1:0]      x_q;
	logic [QP-1:0]               pos_q;
	logic signed [SAMPLE_BITS-1:0] v0_q;
	logic signed [ACW-1:0]       acc_q;
	logic [DatBits-1:0]          prod_q;

	// shared compare-subtract unit state
	logic [DatBits-1:0]          rem_q;
	logic [DatBits-1:0]          dq_q;
	logic [DatBits-1:0]          quot_q;
	logic [DatBits-1:0]          divisor_q;
	logic [5:0]                  cnt_q;

	// output register
	logic                        out_valid_q;
	logic signed [PixelBits-1:0] pixel_q;
	logic [RowBits-1:0]          row_out_q;

	// echo memory
	logic signed [SAMPLE_BITS-1:0] echo_mem [0:(1 << AW)-1];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic                        mem_we;

	// derived values
	logic [NCW-1:0]              ncount;
	logic [NCW-1:0]              rx_div;
	logic [SCW-1:0]              scount;
	logic [RRW-1:0]              row_div;
	logic [RowBits-1:0]          row_clamped;
	logic [23:0]                 speed;
	logic [26:0]                 cx;
	logic [GeoQuotBits-1:0]      dx;
	logic [28:0]                 y_next;
	logic [30:0]                 total;
	logic [SW-1:0]               idx;
	logic [SW-1:0]               idx_next;
	logic                        idx_last;
	logic [31:0]                 rcv_ext;
	logic [31:0]                 smp_ext;
	logic                        in_xfer;

	// shared unit operands
	logic [DatBits-1:0]          op_a;
	logic [DatBits-1:0]          op_b;
	logic [DatBits:0]            diff;
	logic                        ge;

	// multiplier operands
	logic [MulABits-1:0]         mul_a;
	logic [MulBBits-1:0]         mul_b;
	logic [MulABits+MulBBits-1:0] mul_p;

	// interpolation
	logic signed [SAMPLE_BITS:0]    vd;
	logic signed [SAMPLE_BITS+9:0]  vd_f;
	logic signed [SAMPLE_BITS+10:0] interp;
	logic signed [SAMPLE_BITS+2:0]  contrib;

	// saturation
	logic signed [XW-1:0]        acc_x;
	logic signed [PixelBits-1:0] pixel_sat;

	assign in_stall    = (state_q != S_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign row_out     = row_out_q;

	// clamp and guard the configuration values
	always_comb begin
		ncount = (32'(receiver_count_q) > 32'(MAX_RECEIVERS)) ?
			NCW'(MAX_RECEIVERS) : NCW'(receiver_count_q);
		rx_div = (ncount > NCW'(1)) ? ncount - NCW'(1) : NCW'(1);
		scount = (32'(sample_count_q) > 32'(MAX_SAMPLES)) ?
			SCW'(MAX_SAMPLES) : SCW'(sample_count_q);
		row_div = (row_count_q > 11'd1) ? RRW'(row_count_q - 11'd1) : RRW'(1);
		row_clamped = (RRW'(row_in_q) > row_div) ? RowBits'(row_div) : row_in_q;
		speed = (sound_speed_q == 24'd0) ? 24'd1 : sound_speed_q;
		cx = {array_width_q, 7'd0};
		dx = (GeoQuotBits'(cx) > x_q) ? GeoQuotBits'(cx) - x_q : x_q - GeoQuotBits'(cx);
		y_next = 29'(quot_q[GeoQuotBits-1:0]) + 29'({start_depth_q, 8'd0});
		total = 31'(y_q) + 31'(quot_q[29:0]) - 31'({start_depth_q, 8'd0});
		idx = pos_q[QP-1:8];
		idx_next = idx + SW'(1);
		idx_last = (SCW'(idx) + SCW'(1)) == scount;
	end

	// shared compare-subtract: divide step, square-root step or range check
	always_comb begin
		case (state_q)
			S_SQRT: begin
				op_a = rem_q;
				op_b = quot_q + dq_q;
			end
			S_PCHK: begin
				op_a = prod_q;
				op_b = limit_q;
			end
			default: begin
				op_a = {rem_q[DatBits-2:0], dq_q[DatBits-1]};
				op_b = divisor_q;
			end
		endcase
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = !diff[DatBits];
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_TD: begin
				mul_a = MulABits'(speed);
				mul_b = MulBBits'(SpeedScale);
			end
			S_LIM: begin
				mul_a = MulABits'(prod_q[33:0]);
				mul_b = MulBBits'(scount);
			end
			S_ROW: begin
				mul_a = MulABits'(row_clamped);
				mul_b = MulBBits'(area_height_q);
			end
			S_YSQ: begin
				mul_a = MulABits'(y_next);
				mul_b = MulBBits'(y_next);
			end
			S_XM: begin
				mul_a = MulABits'(n_q);
				mul_b = MulBBits'(array_width_q);
			end
			S_DX: begin
				mul_a = MulABits'(dx);
				mul_b = MulBBits'(dx);
			end
			S_PM: begin
				mul_a = MulABits'(total);
				mul_b = MulBBits'(sample_rate_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = MulABits'(mul_a) * MulBBits'(mul_b);
	end

	// echo memory addressing
	always_comb begin
		rcv_ext = 32'(receiver_index);
		smp_ext = 32'(sample_index);
		mem_we  = in_xfer && (func == FUNC_LOAD) &&
			(rcv_ext < 32'(MAX_RECEIVERS)) && (smp_ext < 32'(MAX_SAMPLES));
		wr_addr = {rcv_ext[NW-1:0], smp_ext[SW-1:0]};
		rd_addr = (state_q == S_RD1) ? {n_q[NW-1:0], idx_next} : {n_q[NW-1:0], idx};
	end

	// store loaded samples, read one per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			echo_mem[wr_addr] <= sample_value;
		end
		rd_q <= echo_mem[rd_addr];
	end

	// interpolate between the two neighboring samples
	always_comb begin
		vd      = (SAMPLE_BITS+1)'(rd_q) - (SAMPLE_BITS+1)'(v0_q);
		vd_f    = vd * $signed({1'b0, pos_q[7:0]});
		interp  = (SAMPLE_BITS+11)'($signed({v0_q, 8'd0})) + (SAMPLE_BITS+11)'(vd_f);
		contrib = idx_last ? (SAMPLE_BITS+3)'(v0_q) : interp[SAMPLE_BITS+10:8];
	end

	// saturate the exact sum to the pixel range
	always_comb begin
		acc_x = XW'(acc_q);
		if (acc_x > $signed(XW'(24'h7FFFFF))) begin
			pixel_sat = 24'sh7FFFFF;
		end else if (acc_x < $signed({{(XW-PixelBits){1'b1}}, 24'h800000})) begin
			pixel_sat = 24'sh800000;
		end else begin
			pixel_sat = acc_x[PixelBits-1:0];
		end
	end

	// register the product of every multiplier cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_p[DatBits-1:0];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiver_count_q <= RstReceiverCount;
			sample_count_q   <= RstSampleCount;
			sound_speed_q    <= RstSoundSpeed;
			array_width_q    <= RstArrayWidth;
			sample_rate_q    <= RstSampleRate;
			start_depth_q    <= RstStartDepth;
			area_height_q    <= RstAreaHeight;
			row_count_q      <= RstRowCount;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_RECEIVER_COUNT: receiver_count_q <= wr_data[7:0];
				REG_SAMPLE_COUNT:   sample_count_q   <= wr_data[12:0];
				REG_SOUND_SPEED:    sound_speed_q    <= wr_data[23:0];
				REG_ARRAY_WIDTH:    array_width_q    <= wr_data[19:0];
				REG_SAMPLE_RATE:    sample_rate_q    <= wr_data[27:0];
				REG_START_DEPTH:    start_depth_q    <= wr_data[19:0];
				REG_AREA_HEIGHT:    area_height_q    <= wr_data[19:0];
				REG_ROW_COUNT:      row_count_q      <= wr_data[10:0];
				default: ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			cnt_q       <= '0;
		end else begin
			// raise the result when a pixel is done, drop it once transferred
			if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && (func == FUNC_COMPUTE)) begin
						n_q     <= '0;
						state_q <= S_TD;
					end
				end
				S_TD:   state_q <= S_LIM;
				S_LIM:  state_q <= S_ROW;
				S_ROW:  state_q <= S_YLD;
				S_YLD: begin
					cnt_q   <= 6'(GeoQuotBits - 1);
					state_q <= S_YDIV;
				end
				S_YDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_YSQ;
					end
				end
				S_YSQ:  state_q <= S_YSQW;
				S_YSQW: state_q <= S_XM;
				S_XM: begin
					state_q <= (n_q == ncount) ? S_DONE : S_XLD;
				end
				S_XLD: begin
					cnt_q   <= 6'(GeoQuotBits - 1);
					state_q <= S_XDIV;
				end
				S_XDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_DX;
					end
				end
				S_DX:   state_q <= S_RAD;
				S_RAD: begin
					cnt_q   <= 6'(SqrtSteps - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_PM;
					end
				end
				S_PM:   state_q <= S_PCHK;
				S_PCHK: begin
					// skip a receiver whose echo lies past the recording
					if (ge) begin
						n_q     <= n_q + NCW'(1);
						state_q <= S_XM;
					end else begin
						cnt_q   <= 6'(QP - 1);
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_RD0;
					end
				end
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_INT;
				S_INT: begin
					n_q     <= n_q + NCW'(1);
					state_q <= S_XM;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				row_in_q <= depth_row;
				acc_q    <= '0;
			end
			S_LIM:  time_div_q <= prod_q[33:0];
			S_ROW:  limit_q <= {prod_q[DatBits-9:0], 8'd0};
			S_YLD: begin
				rem_q     <= {prod_q[DatBits-9:0], 8'd0} >> GeoQuotBits;
				dq_q      <= {prod_q[DatBits-9:0], 8'd0} << (DatBits - GeoQuotBits);
				quot_q    <= '0;
				divisor_q <= DatBits'(row_div);
			end
			S_XLD: begin
				rem_q     <= {prod_q[DatBits-9:0], 8'd0} >> GeoQuotBits;
				dq_q      <= {prod_q[DatBits-9:0], 8'd0} << (DatBits - GeoQuotBits);
				quot_q    <= '0;
				divisor_q <= DatBits'(rx_div);
			end
			S_YDIV, S_XDIV, S_PDIV: begin
				// one restoring divide step
				rem_q  <= ge ? diff[DatBits-1:0] : op_a;
				quot_q <= {quot_q[DatBits-2:0], ge};
				dq_q   <= {dq_q[DatBits-2:0], 1'b0};
			end
			S_YSQ: y_q <= y_next;
			S_YSQW: ysq_q <= prod_q;
			S_DX:  x_q <= x_q;
			S_RAD: begin
				rem_q  <= prod_q + ysq_q;
				quot_q <= '0;
				dq_q   <= DatBits'(1) << SqrtTopBit;
			end
			S_SQRT: begin
				// one square-root step, two radicand bits at a time
				if (ge) begin
					rem_q  <= diff[DatBits-1:0];
					quot_q <= (quot_q >> 1) + dq_q;
				end else begin
					quot_q <= quot_q >> 1;
				end
				dq_q <= dq_q >> 2;
			end
			S_PCHK: begin
				rem_q     <= prod_q >> QP;
				dq_q      <= prod_q << (DatBits - QP);
				quot_q    <= '0;
				divisor_q <= DatBits'(time_div_q);
			end
			S_RD1: v0_q <= rd_q;
			S_INT: acc_q <= acc_q + ACW'(contrib);
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					pixel_q   <= pixel_sat;
					row_out_q <= row_in_q;
				end
			end
			default: ;
		endcase
		// latch the lateral position when its divide finishes
		if ((state_q == S_XDIV) && (cnt_q == 6'd0)) begin
			x_q <= {quot_q[GeoQuotBits-2:0], ge};
		end
		// latch the sample position when its divide finishes
		if ((state_q == S_PDIV) && (cnt_q == 6'd0)) begin
			pos_q <= {quot_q[QP-2:0], ge};
		end
	end

endmodule

// File: hw/rtl/dasb_checker.sv
// ----------------------------------------------------------------------------
// dasb_checker: port-level checks of the beamformer
// Watches the handshakes of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
module dasb_checker
	import dasb_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        func,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic signed [PixelBits-1:0] pixel_value,
	input logic [RowBits-1:0]          row_out
);

	// a compute transfer occupies the block
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == FUNC_COMPUTE) |=> in_stall)
		else $error("compute transfer did not stall the input");

	// a load transfer leaves the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == FUNC_LOAD) |=> !in_stall)
		else $error("load transfer stalled the input");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(row_out))
		else $error("stalled result changed");

	// a result appears only at the end of a compute
	a_out_from_compute: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a compute in progress");

endmodule

bind delay_and_sum_beamformer_unit dasb_checker u_dasb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.func        (func),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_value (pixel_value),
	.row_out     (row_out)
);
